// ===== design/xbr_pkg.sv =====
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared types and constants for the XMODEM block receiver.
// ----------------------------------------------------------------------------
package xbr_pkg;

    // Protocol characters
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] IDX_SUM = 8'hFF;

    localparam logic [23:0] TOTAL_MAX = 24'hFF_FFFF;

    // Input function codes
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_BYTE    = 2'd1;
    localparam logic [1:0] FUNC_VERDICT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Command opcodes passed from front to back
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_VERDICT = 2'd2;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic       accept;
    } xbr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [6:0]  byte_offset;
        logic [7:0]  block_number;
        logic        checksum_ok;
        logic        session_end;
        logic [23:0] received_bytes;
    } xbr_out_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic       is_soh;
        logic       is_eot;
        logic       accept;
    } xbr_cmd_t;

endpackage

// ===== design/xmodem_block_receiver.sv =====
// ----------------------------------------------------------------------------
// xmodem_block_receiver
// XMODEM receive engine for fixed-size blocks with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                        Moves
//   -------  ---------------------------  ------------------------------------
//   input    s_valid / s_ready / s_data   start, received byte or verdict
//   result   m_valid / m_ready / m_data   byte to send, data byte, block
//                                         status or index error
//
// One transaction per cycle is sustained in both directions while the result
// port is not stalled. An input passes the decode register and the command
// FIFO (4 entries) before its result, if any, reaches the result register;
// the protocol state machine handles one command a cycle unless the result
// port stalls. Reset (aresetn low, synchronous) empties the pipeline and
// returns the session to idle. A stalled result port holds the state
// machine; the FIFO and decode register keep absorbing input until they fill.
// ----------------------------------------------------------------------------
module xmodem_block_receiver
    import xbr_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  xbr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output xbr_out_t m_data
);

    // Decoded commands between the front and the queue
    logic     fq_valid;
    logic     fq_ready;
    xbr_cmd_t fq_cmd;

    // Commands between the queue and the protocol engine
    logic     qb_valid;
    logic     qb_ready;
    xbr_cmd_t qb_cmd;

    // Decode: classify the function code and pre-flag header characters
    xbr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    // Buffer commands so input keeps flowing while results stall
    xbr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // Execute: session state, index check, checksum, byte total
    xbr_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== design/xbr_front.sv =====
// ----------------------------------------------------------------------------
// xbr_front
// Input stage: accepts items, decodes them into commands, drops no-ops.
// ----------------------------------------------------------------------------
module xbr_front
    import xbr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  xbr_in_t  s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output xbr_cmd_t cmd
);

    logic     valid_reg;
    logic     valid_next;
    xbr_cmd_t cmd_reg;
    xbr_cmd_t cmd_next;
    logic     take;
    logic     keep;

    assign s_ready = !valid_reg || cmd_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        cmd_next.op      = OP_START;
        cmd_next.rx_byte = s_data.rx_byte;
        cmd_next.is_soh  = (s_data.rx_byte == CH_SOH);
        cmd_next.is_eot  = (s_data.rx_byte == CH_EOT);
        cmd_next.accept  = s_data.accept;
        keep             = 1'b1;
        unique case (s_data.func)
            FUNC_START:   cmd_next.op = OP_START;
            FUNC_BYTE:    cmd_next.op = OP_BYTE;
            FUNC_VERDICT: cmd_next.op = OP_VERDICT;
            default:      keep = 1'b0;  // drop unused function code
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = take && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== design/xbr_queue.sv =====
// ----------------------------------------------------------------------------
// xbr_queue
// Small command FIFO decoupling the decode stage from the protocol engine.
// ----------------------------------------------------------------------------
module xbr_queue
    import xbr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  xbr_cmd_t push_cmd,
    output logic     pop_valid,
    input  logic     pop_ready,
    output xbr_cmd_t pop_cmd
);

    xbr_cmd_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/xbr_back.sv =====
// ----------------------------------------------------------------------------
// xbr_back
// Protocol engine: session state machine, block checks and result register.
// ----------------------------------------------------------------------------
module xbr_back
    import xbr_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  xbr_cmd_t cmd,
    output logic     m_valid,
    input  logic     m_ready,
    output xbr_out_t m_data
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HUNT    = 3'd1;
    localparam logic [2:0] PH_INDEX   = 3'd2;
    localparam logic [2:0] PH_COMPL   = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_CSUM    = 3'd5;
    localparam logic [2:0] PH_VERDICT = 3'd6;

    localparam logic [7:0]  LAST_COUNT = 8'(BLOCK_BYTES);
    localparam logic [23:0] SAT_LIMIT  = TOTAL_MAX - 24'(BLOCK_BYTES);

    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  index_reg,   index_next;
    logic [7:0]  count_reg,   count_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [23:0] total_reg,   total_next;
    logic        m_valid_reg;
    xbr_out_t    m_data_reg;
    logic        res_valid;
    xbr_out_t    res;
    logic        fire;
    logic [7:0]  count_inc;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign count_inc = count_reg + 8'd1;

    always_comb begin
        phase_next = phase_reg;
        index_next = index_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (fire) begin
            unique case (cmd.op)
                OP_START: begin
                    total_next = '0;
                    count_next = '0;
                    sum_next   = '0;
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res.kind   = KIND_SEND;
                    res.value  = CH_NAK;
                end
                OP_VERDICT: begin
                    if (phase_reg == PH_VERDICT) begin
                        total_next = (total_reg > SAT_LIMIT) ? TOTAL_MAX
                                   : total_reg + 24'(BLOCK_BYTES);
                        phase_next = PH_HUNT;
                        res_valid  = 1'b1;
                        res.kind   = KIND_SEND;
                        res.value  = cmd.accept ? CH_ACK : CH_NAK;
                    end
                end
                OP_BYTE: begin
                    unique case (phase_reg)
                        PH_HUNT: begin
                            if (cmd.is_soh) begin
                                phase_next = PH_INDEX;
                            end else if (cmd.is_eot) begin
                                phase_next      = PH_IDLE;
                                res_valid       = 1'b1;
                                res.kind        = KIND_SEND;
                                res.value       = CH_ACK;
                                res.session_end = 1'b1;
                            end
                        end
                        PH_INDEX: begin
                            index_next = cmd.rx_byte;
                            phase_next = PH_COMPL;
                        end
                        PH_COMPL: begin
                            if (index_reg + cmd.rx_byte != IDX_SUM) begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res.kind   = KIND_ERROR;
                            end else begin
                                count_next = '0;
                                sum_next   = '0;
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_DATA;
                            res.value       = cmd.rx_byte;
                            res.byte_offset = count_reg[6:0];
                            sum_next        = sum_reg + cmd.rx_byte;
                            count_next      = count_inc;
                            if (count_inc >= LAST_COUNT) begin
                                phase_next = PH_CSUM;
                            end
                        end
                        PH_CSUM: begin
                            phase_next      = PH_VERDICT;
                            res_valid       = 1'b1;
                            res.kind        = KIND_BLOCK;
                            res.checksum_ok = (cmd.rx_byte == sum_reg);
                        end
                        default: ;  // idle, verdict wait, unused codes: drop
                    endcase
                end
                default: ;
            endcase
        end
        res.block_number   = index_next;
        res.received_bytes = total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            index_reg   <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            total_reg <= total_next;
            if (cmd_ready) begin
                m_valid_reg <= fire && res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
